// ===== hw/rtl/ets_pkg.sv =====
// shared types and constants of the expression token scanner
package ets_pkg;

  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned FieldW        = 16;

  typedef enum logic [3:0] {
    KIND_LPAREN = 4'd0,
    KIND_RPAREN = 4'd1,
    KIND_PLUS   = 4'd2,
    KIND_MINUS  = 4'd3,
    KIND_STAR   = 4'd4,
    KIND_SLASH  = 4'd5,
    KIND_EQUAL  = 4'd6,
    KIND_NUMBER = 4'd7,
    KIND_IDENT  = 4'd8,
    KIND_END    = 4'd9
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_INT   = 4'b0010,
    MODE_FRAC  = 4'b0100,
    MODE_IDENT = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [FieldW-1:0] offset;
    logic [FieldW-1:0] length;
    logic              run_last;
    logic              stream_done;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/ets_in_if.sv =====
// byte channel into the scanner
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_byte;

  modport source(output valid, char_code, final_byte, input ready);
  modport sink(input valid, char_code, final_byte, output ready);
endinterface

// ===== hw/rtl/ets_out_if.sv =====
// token channel out of the scanner
interface ets_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_offset;
  logic [15:0] token_length;
  logic        run_last;
  logic        stream_done;

  modport source(output valid, token_kind, token_offset, token_length, run_last, stream_done,
                 input ready);
  modport sink(input valid, token_kind, token_offset, token_length, run_last, stream_done,
               output ready);
endinterface

// ===== hw/rtl/expression_token_scanner.sv =====
// top level of the expression token scanner
// a byte's tokens enter the entry queue when it is transferred; the back end offers the head
// throughput: one byte per cycle in while the queue is not full; one token per cycle out while the
// receiver is ready; the entry queue absorbs the extra output of a byte closing two tokens
// reset: asynchronous active low, clears scan mode, token start, byte position and the queue
module expression_token_scanner #(
  parameter int unsigned OffsetBits = ets_pkg::OffsetBitsDef,
  parameter int unsigned QueueDepth = ets_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ets_in_if.sink    byte_i,
  ets_out_if.source token_o
);

  logic               push, pop;
  ets_pkg::entry_t    push_data, head;
  ets_pkg::q_status_t status;

  ets_front #(
    .OffsetBits(OffsetBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .q_status_i (status),
    .push_o     (push),
    .entry_o    (push_data)
  );

  ets_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (status)
  );

  ets_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (status),
    .pop_o    (pop),
    .token_o  (token_o)
  );

endmodule

// ===== hw/rtl/ets_front.sv =====
// byte classification, scan state and token building
module ets_front #(
  parameter int unsigned OffsetBits = ets_pkg::OffsetBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ets_in_if.sink              byte_i,
  input  ets_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output ets_pkg::entry_t     entry_o
);

  localparam int unsigned WideW = (OffsetBits > ets_pkg::FieldW) ? OffsetBits : ets_pkg::FieldW;
  localparam logic [OffsetBits-1:0] PosMax = {OffsetBits{1'b1}};

  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChEqual  = 8'h3d;
  localparam logic [7:0] ChDot    = 8'h2e;

  function automatic logic [ets_pkg::FieldW-1:0] clip(input logic [OffsetBits-1:0] v);
    logic [WideW-1:0] w;
    w = WideW'(v);
    clip = (w > WideW'({ets_pkg::FieldW{1'b1}})) ? {ets_pkg::FieldW{1'b1}}
                                                 : w[ets_pkg::FieldW-1:0];
  endfunction

  ets_pkg::mode_e          mode_q, mode_d, mode_b;
  logic [OffsetBits-1:0]   start_q, start_d, start_b;
  logic [OffsetBits-1:0]   pos_q, pos_d, nxt;
  logic                    accept, fin;
  logic                    is_dig, is_let, is_op, cont;
  ets_pkg::kind_e          op_kind;
  logic                    e_pend, e_op, e_fin, e_end;
  ets_pkg::token_t         t_pend, t_op, t_fin, t_end, s0, s1;
  logic                    two, any;

  assign byte_i.ready = !q_status_i.full;
  assign accept       = byte_i.valid && byte_i.ready;
  assign fin          = byte_i.final_byte;

  always_comb begin
    is_dig  = (byte_i.char_code >= 8'h30) && (byte_i.char_code <= 8'h39);
    is_let  = ((byte_i.char_code >= 8'h61) && (byte_i.char_code <= 8'h7a)) ||
              ((byte_i.char_code >= 8'h41) && (byte_i.char_code <= 8'h5a));
    is_op   = 1'b1;
    op_kind = ets_pkg::KIND_LPAREN;
    unique case (byte_i.char_code)
      ChLparen: op_kind = ets_pkg::KIND_LPAREN;
      ChRparen: op_kind = ets_pkg::KIND_RPAREN;
      ChPlus:   op_kind = ets_pkg::KIND_PLUS;
      ChMinus:  op_kind = ets_pkg::KIND_MINUS;
      ChStar:   op_kind = ets_pkg::KIND_STAR;
      ChSlash:  op_kind = ets_pkg::KIND_SLASH;
      ChEqual:  op_kind = ets_pkg::KIND_EQUAL;
      default:  is_op = 1'b0;
    endcase
  end

  always_comb begin
    nxt    = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
    cont   = 1'b0;
    mode_b = mode_q;
    unique case (mode_q)
      ets_pkg::MODE_INT: begin
        cont = is_dig || (byte_i.char_code == ChDot);
        if (byte_i.char_code == ChDot) begin
          mode_b = ets_pkg::MODE_FRAC;
        end
      end
      ets_pkg::MODE_FRAC:  cont = is_dig;
      ets_pkg::MODE_IDENT: cont = is_dig || is_let;
      default:             cont = 1'b0;
    endcase
    start_b = start_q;
    e_pend  = !cont && (mode_q != ets_pkg::MODE_IDLE);
    e_op    = !cont && is_op;
    if (!cont) begin
      mode_b = ets_pkg::MODE_IDLE;
      if (!is_op && is_dig) begin
        mode_b  = ets_pkg::MODE_INT;
        start_b = pos_q;
      end else if (!is_op && is_let) begin
        mode_b  = ets_pkg::MODE_IDENT;
        start_b = pos_q;
      end
    end
    e_fin = fin && (mode_b != ets_pkg::MODE_IDLE);
    e_end = fin && !e_pend && !e_op && !e_fin;

    t_pend.kind        = (mode_q == ets_pkg::MODE_IDENT) ? ets_pkg::KIND_IDENT
                                                         : ets_pkg::KIND_NUMBER;
    t_pend.offset      = clip(start_q);
    t_pend.length      = clip(pos_q - start_q);
    t_pend.run_last    = 1'b0;
    t_pend.stream_done = 1'b0;

    t_op.kind          = op_kind;
    t_op.offset        = clip(pos_q);
    t_op.length        = ets_pkg::FieldW'(1);
    t_op.run_last      = 1'b1;
    t_op.stream_done   = fin;

    t_fin.kind         = (mode_b == ets_pkg::MODE_IDENT) ? ets_pkg::KIND_IDENT
                                                         : ets_pkg::KIND_NUMBER;
    t_fin.offset       = clip(start_b);
    t_fin.length       = clip(nxt - start_b);
    t_fin.run_last     = 1'b1;
    t_fin.stream_done  = 1'b1;

    t_end.kind         = ets_pkg::KIND_END;
    t_end.offset       = clip(nxt);
    t_end.length       = '0;
    t_end.run_last     = 1'b1;
    t_end.stream_done  = 1'b1;

    two = e_pend && (e_op || e_fin);
    any = e_pend || e_op || e_fin || e_end;

    if (e_pend) begin
      s0 = t_pend;
    end else if (e_op) begin
      s0 = t_op;
    end else if (e_fin) begin
      s0 = t_fin;
    end else begin
      s0 = t_end;
    end
    s1 = e_op ? t_op : t_fin;
    if (!two) begin
      s0.run_last    = 1'b1;
      s0.stream_done = fin;
    end
  end

  assign entry_o.first  = s0;
  assign entry_o.second = s1;
  assign entry_o.two    = two;
  assign push_o         = accept && any;

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    pos_d   = pos_q;
    if (accept) begin
      if (fin) begin
        mode_d  = ets_pkg::MODE_IDLE;
        start_d = '0;
        pos_d   = '0;
      end else begin
        mode_d  = mode_b;
        start_d = start_b;
        pos_d   = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ets_pkg::MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

  a_fin_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fin |=> (pos_q == '0) && (mode_q == ets_pkg::MODE_IDLE))
    else $error("scan state not cleared after final byte");

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !fin && (pos_q != PosMax) |=> pos_q == $past(pos_q) + 1'b1)
    else $error("byte position did not advance");

  a_fin_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fin |-> push_o && (two ? entry_o.second.stream_done : entry_o.first.stream_done))
    else $error("final byte produced no closing token");

endmodule

// ===== hw/rtl/ets_queue.sv =====
// short token queue between front and back
module ets_queue #(
  parameter int unsigned Depth = ets_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ets_pkg::entry_t    push_data_i,
  input  logic               pop_i,
  output ets_pkg::entry_t    head_o,
  output ets_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ets_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/ets_back.sv =====
// serialises queued token pairs onto the output channel
module ets_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ets_pkg::entry_t    head_i,
  input  ets_pkg::q_status_t status_i,
  output logic               pop_o,
  ets_out_if.source          token_o
);

  logic            sel_q, sel_d;
  logic            xfer;
  ets_pkg::token_t cur;

  assign cur                  = sel_q ? head_i.second : head_i.first;
  assign token_o.valid        = !status_i.empty;
  assign token_o.token_kind   = cur.kind;
  assign token_o.token_offset = cur.offset;
  assign token_o.token_length = cur.length;
  assign token_o.run_last     = cur.run_last;
  assign token_o.stream_done  = cur.stream_done;

  assign xfer  = token_o.valid && token_o.ready;
  assign pop_o = xfer && (sel_q || !head_i.two);
  assign sel_d = xfer ? (head_i.two && !sel_q) : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ===== sim/tb_expression_token_scanner.sv =====
// testbench of the expression token scanner: directed and random byte streams checked against a token predictor
module tb_expression_token_scanner;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OB = ets_pkg::OffsetBitsDef;
  localparam longint unsigned POS_MAX = (64'd1 << OB) - 1;
  localparam longint unsigned FIELD_MAX = 64'hFFFF;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } src_byte_t;

  logic clk_i;
  logic rst_ni;

  ets_in_if  byte_if ();
  ets_out_if token_if ();

  expression_token_scanner uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .token_o(token_if)
  );

  src_byte_t       feed_q[$];
  ets_pkg::token_t token_q[$];
  src_byte_t       nxt;

  ets_pkg::mode_e  cur_mode = ets_pkg::MODE_IDLE;
  longint unsigned tok_start = 0;
  longint unsigned next_pos = 0;

  int mismatches = 0;
  int bytes_sent = 0;
  int send_gap = 0;
  int recv_stall = 0;

  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] clip16(input longint unsigned v);
    return (v > FIELD_MAX) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit op_of(input logic [7:0] c, output ets_pkg::kind_e k);
    op_of = 1'b1;
    k = ets_pkg::KIND_END;
    case (c)
      "(": k = ets_pkg::KIND_LPAREN;
      ")": k = ets_pkg::KIND_RPAREN;
      "+": k = ets_pkg::KIND_PLUS;
      "-": k = ets_pkg::KIND_MINUS;
      "*": k = ets_pkg::KIND_STAR;
      "/": k = ets_pkg::KIND_SLASH;
      "=": k = ets_pkg::KIND_EQUAL;
      default: op_of = 1'b0;
    endcase
  endfunction

  function automatic ets_pkg::kind_e pending_kind();
    return (cur_mode == ets_pkg::MODE_IDENT) ? ets_pkg::KIND_IDENT : ets_pkg::KIND_NUMBER;
  endfunction

  task automatic push_token(input ets_pkg::kind_e k, input longint unsigned off,
                            input longint unsigned len);
    ets_pkg::token_t t;
    t.kind = k;
    t.offset = clip16(off);
    t.length = clip16(len);
    t.run_last = 1'b0;
    t.stream_done = 1'b0;
    token_q = {token_q, t};
  endtask

  // tokens caused by one transferred byte
  task automatic predict_byte(input logic [7:0] c, input logic fin);
    longint unsigned here;
    longint unsigned after;
    bit grows;
    int n_before;
    ets_pkg::kind_e opk;
    ets_pkg::token_t t;
    here = next_pos;
    after = (here < POS_MAX) ? here + 1 : POS_MAX;
    n_before = token_q.size();
    case (cur_mode)
      ets_pkg::MODE_INT: begin
        grows = is_digit(c) || c == ".";
        if (c == ".") cur_mode = ets_pkg::MODE_FRAC;
      end
      ets_pkg::MODE_FRAC:  grows = is_digit(c);
      ets_pkg::MODE_IDENT: grows = is_digit(c) || is_letter(c);
      default:             grows = 1'b0;
    endcase
    if (!grows) begin
      if (cur_mode != ets_pkg::MODE_IDLE) begin
        push_token(pending_kind(), tok_start, here - tok_start);
        cur_mode = ets_pkg::MODE_IDLE;
      end
      if (op_of(c, opk)) begin
        push_token(opk, here, 1);
      end else if (is_digit(c)) begin
        cur_mode = ets_pkg::MODE_INT;
        tok_start = here;
      end else if (is_letter(c)) begin
        cur_mode = ets_pkg::MODE_IDENT;
        tok_start = here;
      end
    end
    next_pos = after;
    if (fin) begin
      if (cur_mode != ets_pkg::MODE_IDLE) push_token(pending_kind(), tok_start, after - tok_start);
      if (token_q.size() == n_before) push_token(ets_pkg::KIND_END, after, 0);
      t = token_q.pop_back();
      t.stream_done = 1'b1;
      token_q = {token_q, t};
      cur_mode = ets_pkg::MODE_IDLE;
      tok_start = 0;
      next_pos = 0;
    end
    if (token_q.size() > n_before) begin
      t = token_q.pop_back();
      t.run_last = 1'b1;
      token_q = {token_q, t};
    end
  endtask

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_token();
    ets_pkg::token_t want;
    if (token_q.size() == 0) begin
      mismatches++;
      $display("%0t: token expected none actual kind %0d offset %0d length %0d", $time,
               token_if.token_kind, token_if.token_offset, token_if.token_length);
    end else begin
      want = token_q.pop_front();
      check_field("token_kind", want.kind, token_if.token_kind);
      check_field("token_offset", want.offset, token_if.token_offset);
      check_field("token_length", want.length, token_if.token_length);
      check_field("run_last", want.run_last, token_if.run_last);
      check_field("stream_done", want.stream_done, token_if.stream_done);
    end
  endtask

  // no idling near the end, and none in one stretch out of four
  function automatic bit idling_on();
    return feed_q.size() >= QUIET_TAIL && ((bytes_sent >> 8) % 4) != 3;
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      byte_if.char_code <= '0;
      byte_if.final_byte <= 1'b0;
      send_gap = 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        predict_byte(byte_if.char_code, byte_if.final_byte);
        bytes_sent++;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_if.valid <= 1'b0;
        end else if (feed_q.size() == 0) begin
          byte_if.valid <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          byte_if.valid <= 1'b0;
        end else begin
          nxt = feed_q.pop_front();
          byte_if.valid <= 1'b1;
          byte_if.char_code <= nxt.code;
          byte_if.final_byte <= nxt.fin;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (token_if.valid && token_if.ready) check_token();
      if (recv_stall > 0) begin
        recv_stall--;
        token_if.ready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(0, 3);
        token_if.ready <= 1'b0;
      end else begin
        token_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] c, input logic f);
    src_byte_t b;
    b.code = c;
    b.fin = f;
    feed_q = {feed_q, b};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic close_source();
    src_byte_t b;
    b = feed_q.pop_back();
    b.fin = 1'b1;
    feed_q = {feed_q, b};
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_space();
    string ws;
    ws = " \t\r\n";
    return ws[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] rand_op();
    string ops;
    ops = "()+-*/=";
    return ops[$urandom_range(0, 6)];
  endfunction

  task automatic push_number();
    int nd;
    nd = $urandom_range(1, 5);
    for (int i = 0; i < nd; i++) push_byte(rand_digit(), 1'b0);
    if ($urandom_range(0, 2) == 0) begin
      push_byte(".", 1'b0);
      nd = $urandom_range(0, 3);
      for (int i = 0; i < nd; i++) push_byte(rand_digit(), 1'b0);
      if ($urandom_range(0, 5) == 0) begin
        push_byte(".", 1'b0);
        push_byte(rand_digit(), 1'b0);
      end
    end
  endtask

  task automatic push_ident();
    int nc;
    nc = $urandom_range(0, 6);
    push_byte(rand_letter(), 1'b0);
    for (int i = 0; i < nc; i++)
      push_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter(), 1'b0);
  endtask

  task automatic push_gap(input bit noisy);
    if ($urandom_range(0, 2) == 0) push_byte(rand_space(), 1'b0);
    if (noisy && $urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic push_operand(input bit noisy);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_number();
      4, 5, 6:    push_ident();
      7: begin
        push_byte("(", 1'b0);
        if ($urandom_range(0, 1)) push_ident();
        else push_number();
        push_byte(rand_op(), 1'b0);
        push_number();
        push_byte(")", 1'b0);
      end
      8: begin
        push_byte("-", 1'b0);
        push_number();
      end
      default: begin
        if (noisy) push_byte(8'($urandom_range(0, 255)), 1'b0);
        else push_ident();
      end
    endcase
  endtask

  task automatic add_source(input bit noisy, input int min_len);
    int start_sz;
    int terms;
    int k;
    start_sz = feed_q.size();
    terms = $urandom_range(1, 6);
    k = 0;
    push_operand(noisy);
    while (k < terms - 1 || feed_q.size() - start_sz < min_len) begin
      push_gap(noisy);
      push_byte(rand_op(), 1'b0);
      push_gap(noisy);
      push_operand(noisy);
      k++;
    end
    if ($urandom_range(0, 3) == 0) push_byte(rand_space(), 1'b0);
    close_source();
  endtask

  task automatic pick_source();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
    else add_source(r <= 3, 0);
  endtask

  initial begin
    int target;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.char_code = '0;
    byte_if.final_byte = 1'b0;
    token_if.ready = 1'b0;

    // byte code extremes, every operator, dots, letter after number, final-byte closures
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("(a1+1.5.7z)-*/=.");
    push_text("9.");
    close_source();
    push_byte(" ", 1'b1);
    push_byte("7", 1'b1);
    push_byte("+", 1'b1);
    push_text("x)");
    close_source();

    while (feed_q.size() < 900) pick_source();
    target = feed_q.size() + 800;
    while (feed_q.size() < target) pick_source();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_q.size() != 0 || byte_if.valid || token_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && token_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
